// ===== src/rba_pkg.sv =====
// shared types, codes and helpers for the reference-counted block allocator
// no dependencies; imported by every module of the block but rba_ram
package rba_pkg;

    localparam int RBA_MAX_BLOCKS   = 4096;
    localparam int RBA_WORD_BITS    = 64;
    localparam int RBA_WORD_LOG     = 6;
    localparam int RBA_CFG_WIDTH    = 32;
    localparam int RBA_TOTAL_WIDTH  = 13;
    localparam int RBA_COUNT_WIDTH  = 8;

    localparam logic [RBA_COUNT_WIDTH-1:0] RBA_COUNT_LIMIT = 8'd255;
    localparam logic [RBA_COUNT_WIDTH-1:0] RBA_COUNT_ONE   = 8'd1;
    localparam logic [RBA_TOTAL_WIDTH-1:0] RBA_TOTAL_RESET = 13'd4096;

    typedef enum logic [2:0] {
        CMD_ALLOC = 3'd0,
        CMD_FREE  = 3'd1,
        CMD_INC   = 3'd2,
        CMD_DEC   = 3'd3,
        CMD_QUERY = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_SPACE = 2'd1,
        STS_INVALID  = 2'd2,
        STS_RANGE    = 2'd3
    } status_t;

    typedef enum logic {
        REG_DATA_BASE  = 1'b0,
        REG_DATA_TOTAL = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_MODIFY,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] block_number;
    } cmd_item_t;

    typedef struct packed {
        status_t                      status;
        logic [31:0]                  granted_block;
        logic [RBA_COUNT_WIDTH-1:0]   reference_count;
        logic                         is_allocated;
        logic [RBA_TOTAL_WIDTH-1:0]   blocks_free;
    } rsp_item_t;

    // lowest set bit of a map word: {found, position}
    function automatic logic [RBA_WORD_LOG:0] rba_first_set(
        input logic [RBA_WORD_BITS-1:0] bits
    );
        logic [RBA_WORD_LOG:0] res;
        res = '0;
        for (int i = RBA_WORD_BITS - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                res = {1'b1, RBA_WORD_LOG'(i)};
            end
        end
        return res;
    endfunction

endpackage

// ===== src/rba_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies; holds the allocation map words and the reference counts
module rba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/rba_summary.sv =====
// one full flag per allocation map word and a search for the first open word
// depends on rba_pkg (word size, first-set helper)
module rba_summary #(
    parameter int NW  = 64,
    parameter int WIW = 6,
    parameter int CIW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           upd_we,
    input  logic [WIW-1:0] upd_addr,
    input  logic           upd_full,
    input  logic [CIW-1:0] chunk,
    output logic           found,
    output logic [WIW-1:0] word
);
    import rba_pkg::*;

    logic [NW-1:0]            full_reg;
    logic [NW-1:0]            full_next;
    logic [RBA_WORD_BITS-1:0] open_bits;
    logic [RBA_WORD_LOG:0]    hit;
    logic [31:0]              widx;

    // track map word writes
    always_comb
    begin
        full_next = full_reg;
        if (upd_we)
        begin
            full_next[upd_addr] = upd_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // first word with a clear bit inside the selected chunk of flags
    always_comb
    begin
        open_bits = '0;
        widx      = '0;
        for (int j = 0; j < RBA_WORD_BITS; j++)
        begin
            widx = (32'(chunk) << RBA_WORD_LOG) + 32'(j);
            if (widx < 32'(NW))
            begin
                open_bits[j] = ~full_reg[widx[WIW-1:0]];
            end
        end
        hit   = rba_first_set(open_bits);
        found = hit[RBA_WORD_LOG];
        word  = WIW'((32'(chunk) << RBA_WORD_LOG) + 32'(hit[RBA_WORD_LOG-1:0]));
    end

endmodule

// ===== src/refcounted_block_allocator.sv =====
// top level: command sequencer, config registers and the two state memories
// depends on rba_pkg, rba_ram and rba_summary
//
// Manages up to MAX_BLOCKS data blocks with one allocation bit and one 8-bit
// reference count each, both kept in synchronous rams (map in 64-bit words).
// After reset the block runs a clearing pass over all MAX_BLOCKS entries (map to
// free, counts to one) with cmd_ready low; config writes are taken meanwhile.
// Commands are handled one at a time as a read-modify-write of one map word
// and one count: free, inc, dec and query on a valid address pass through
// accept, lookup and ram read, modify and write back, and result hand-off;
// a bad address, an unknown code or an alloc with no free count left goes
// from lookup straight to the hand-off. Alloc adds a scan of the per-word
// full flags, 64 flags a cycle, between lookup and modify. A result waits
// in an output register, so a new command is taken while it is still
// pending; the one after that holds in the hand-off step until the waiting
// result is taken.
module refcounted_block_allocator #(
    parameter int MAX_BLOCKS = rba_pkg::RBA_MAX_BLOCKS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  rba_pkg::cmd_item_t               cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output rba_pkg::rsp_item_t               rsp,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [rba_pkg::RBA_CFG_WIDTH-1:0] cfg_data
);
    import rba_pkg::*;

    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int NW  = (MAX_BLOCKS + RBA_WORD_BITS - 1) / RBA_WORD_BITS;
    localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
    localparam int NC  = (NW + RBA_WORD_BITS - 1) / RBA_WORD_BITS;
    localparam int CIW = (NC > 1) ? $clog2(NC) : 1;
    localparam int UW  = $clog2(MAX_BLOCKS + 1);

    // control registers
    state_t                     state_reg, state_next;
    logic [IW-1:0]              clr_reg, clr_next;
    logic [UW-1:0]              used_reg, used_next;
    logic [31:0]                base_reg, base_next;
    logic [RBA_TOTAL_WIDTH-1:0] total_reg, total_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    logic [CIW-1:0]             chunk_reg, chunk_next;

    // payload registers
    logic [2:0]                 command_reg, command_next;
    logic [31:0]                blk_reg, blk_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [WIW-1:0]             word_reg, word_next;
    rsp_item_t                  res_reg, res_next;
    rsp_item_t                  rsp_reg, rsp_next;

    // memory ports
    logic                       map_we, map_re;
    logic [WIW-1:0]             map_waddr, map_raddr;
    logic [RBA_WORD_BITS-1:0]   map_wdata, map_rdata;
    logic                       cnt_we, cnt_re;
    logic [IW-1:0]              cnt_waddr, cnt_raddr;
    logic [RBA_COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;

    // summary search
    logic                       sum_found;
    logic [WIW-1:0]             sum_word;

    // derived values
    logic [RBA_TOTAL_WIDTH-1:0] eff_total;
    logic [RBA_TOTAL_WIDTH-1:0] free_now;
    logic [32:0]                diff;
    logic                       addr_ok;
    logic [IW-1:0]              lk_idx;

    rba_ram #(
        .WIDTH (RBA_WORD_BITS),
        .DEPTH (NW),
        .AW    (WIW)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    rba_ram #(
        .WIDTH (RBA_COUNT_WIDTH),
        .DEPTH (MAX_BLOCKS),
        .AW    (IW)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    rba_summary #(
        .NW  (NW),
        .WIW (WIW),
        .CIW (CIW)
    ) u_summary (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_we   (map_we),
        .upd_addr (map_waddr),
        .upd_full (&map_wdata),
        .chunk    (chunk_reg),
        .found    (sum_found),
        .word     (sum_word)
    );

    // effective total, free count and address check
    always_comb
    begin
        if (32'(total_reg) > 32'(MAX_BLOCKS))
        begin
            eff_total = RBA_TOTAL_WIDTH'(MAX_BLOCKS);
        end
        else
        begin
            eff_total = total_reg;
        end
        if (32'(eff_total) > 32'(used_reg))
        begin
            free_now = RBA_TOTAL_WIDTH'(32'(eff_total) - 32'(used_reg));
        end
        else
        begin
            free_now = '0;
        end
        diff    = {1'b0, blk_reg} - {1'b0, base_reg};
        addr_ok = !diff[32] && (diff[31:0] < 32'(eff_total));
        lk_idx  = IW'(diff[31:0]);
    end

    // config writes
    always_comb
    begin
        base_next  = base_reg;
        total_next = total_reg;
        if (cfg_we)
        begin
            if (cfg_index == REG_DATA_BASE)
            begin
                base_next = cfg_data;
            end
            else
            begin
                total_next = RBA_TOTAL_WIDTH'(cfg_data);
            end
        end
    end

    // sequencer: lookup, scan, read-modify-write, result hand-off
    always_comb
    begin
        logic [RBA_WORD_LOG:0]      pick;
        logic [31:0]                alloc_idx;
        logic [RBA_WORD_LOG-1:0]    off;
        logic                       bit_now;
        logic [RBA_COUNT_WIDTH-1:0] count_now;
        logic [RBA_WORD_BITS-1:0]   bit_mask;

        state_next     = state_reg;
        clr_next       = clr_reg;
        used_next      = used_reg;
        chunk_next     = chunk_reg;
        command_next   = command_reg;
        blk_next       = blk_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        cmd_ready      = 1'b0;

        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = '0;
        map_re    = 1'b0;
        map_raddr = '0;
        cnt_we    = 1'b0;
        cnt_waddr = '0;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = '0;

        pick      = rba_first_set(~map_rdata);
        alloc_idx = (32'(word_reg) << RBA_WORD_LOG) + 32'(pick[RBA_WORD_LOG-1:0]);
        off       = RBA_WORD_LOG'(32'(idx_reg));
        bit_now   = map_rdata[off];
        count_now = cnt_rdata;
        bit_mask  = {{(RBA_WORD_BITS-1){1'b0}}, 1'b1} << off;

        case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = WIW'(32'(clr_reg) >> RBA_WORD_LOG);
                map_wdata = '0;
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = RBA_COUNT_ONE;
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == IW'(MAX_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    command_next = cmd.command;
                    blk_next     = cmd.block_number;
                    state_next   = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                res_next = '0;
                case (command_reg)
                    CMD_ALLOC:
                    begin
                        if (free_now == '0)
                        begin
                            res_next.status = STS_NO_SPACE;
                            state_next      = S_PUSH;
                        end
                        else
                        begin
                            chunk_next = '0;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_FREE, CMD_INC, CMD_DEC, CMD_QUERY:
                    begin
                        if (!addr_ok)
                        begin
                            res_next.status = STS_INVALID;
                            state_next      = S_PUSH;
                        end
                        else
                        begin
                            idx_next   = lk_idx;
                            map_re     = 1'b1;
                            map_raddr  = WIW'(32'(lk_idx) >> RBA_WORD_LOG);
                            cnt_re     = 1'b1;
                            cnt_raddr  = lk_idx;
                            state_next = S_MODIFY;
                        end
                    end
                    default:
                    begin
                        res_next.status = STS_INVALID;
                        state_next      = S_PUSH;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (sum_found)
                begin
                    word_next  = sum_word;
                    map_re     = 1'b1;
                    map_raddr  = sum_word;
                    state_next = S_MODIFY;
                end
                else if (chunk_reg == CIW'(NC - 1))
                begin
                    res_next.status = STS_NO_SPACE;
                    state_next      = S_PUSH;
                end
                else
                begin
                    chunk_next = chunk_reg + CIW'(1);
                end
            end

            S_MODIFY:
            begin
                state_next = S_PUSH;
                res_next   = '0;
                if (command_reg == CMD_ALLOC)
                begin
                    // lowest clear bit of the first open word
                    if (pick[RBA_WORD_LOG] && (alloc_idx < 32'(eff_total)))
                    begin
                        map_we    = 1'b1;
                        map_waddr = word_reg;
                        map_wdata = map_rdata |
                            ({{(RBA_WORD_BITS-1){1'b0}}, 1'b1} << pick[RBA_WORD_LOG-1:0]);
                        cnt_we    = 1'b1;
                        cnt_waddr = IW'(alloc_idx);
                        cnt_wdata = RBA_COUNT_ONE;
                        used_next = used_reg + UW'(1);
                        res_next.status          = STS_OK;
                        res_next.granted_block   = base_reg + alloc_idx;
                        res_next.reference_count = RBA_COUNT_ONE;
                        res_next.is_allocated    = 1'b1;
                    end
                    else
                    begin
                        res_next.status = STS_NO_SPACE;
                    end
                end
                else
                begin
                    map_waddr = WIW'(32'(idx_reg) >> RBA_WORD_LOG);
                    map_wdata = map_rdata & ~bit_mask;
                    cnt_waddr = idx_reg;
                    res_next.reference_count = count_now;
                    res_next.is_allocated    = bit_now;
                    case (command_reg)
                        CMD_FREE:
                        begin
                            if (!bit_now)
                            begin
                                res_next.status = STS_INVALID;
                            end
                            else if (count_now > RBA_COUNT_ONE)
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = count_now - RBA_COUNT_ONE;
                                res_next.reference_count = cnt_wdata;
                            end
                            else
                            begin
                                // last reference: release the block
                                cnt_we    = 1'b1;
                                cnt_wdata = '0;
                                map_we    = 1'b1;
                                if (used_reg != '0)
                                begin
                                    used_next = used_reg - UW'(1);
                                end
                                res_next.reference_count = '0;
                                res_next.is_allocated    = 1'b0;
                            end
                        end
                        CMD_INC:
                        begin
                            if (count_now == RBA_COUNT_LIMIT)
                            begin
                                res_next.status = STS_RANGE;
                            end
                            else
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = count_now + RBA_COUNT_ONE;
                                res_next.reference_count = cnt_wdata;
                            end
                        end
                        CMD_DEC:
                        begin
                            if (count_now == '0)
                            begin
                                res_next.status = STS_RANGE;
                            end
                            else
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = count_now - RBA_COUNT_ONE;
                                res_next.reference_count = cnt_wdata;
                                // reaching zero releases an allocated block
                                if ((count_now == RBA_COUNT_ONE) && bit_now)
                                begin
                                    map_we = 1'b1;
                                    if (used_reg != '0)
                                    begin
                                        used_next = used_reg - UW'(1);
                                    end
                                    res_next.is_allocated = 1'b0;
                                end
                            end
                        end
                        CMD_QUERY:
                        begin
                            res_next.status = STS_OK;
                        end
                        default:
                        begin
                            res_next = '0;
                            res_next.status = STS_INVALID;
                        end
                    endcase
                end
            end

            S_PUSH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next             = res_reg;
                    rsp_next.blocks_free = free_now;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            base_reg      <= '0;
            total_reg     <= RBA_TOTAL_RESET;
            rsp_valid_reg <= 1'b0;
            chunk_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            base_reg      <= base_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
            chunk_reg     <= chunk_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        command_reg <= command_next;
        blk_reg     <= blk_next;
        idx_reg     <= idx_next;
        word_reg    <= word_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // used count can never pass the map depth
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(MAX_BLOCKS))
        else $error("used block count exceeds map depth");

    // an accepted transaction always goes to lookup next
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg == S_LOOKUP))
        else $error("accepted transaction did not enter lookup");

    // a failed transaction never grants a block
    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != STS_OK)) |-> (rsp.granted_block == '0))
        else $error("failed transaction carries a granted block");

    // map is written only by the clearing pass or the write-back step
    a_map_write: assert property (@(posedge clk) disable iff (!rst_n)
        map_we |-> ((state_reg == S_CLEAR) || (state_reg == S_MODIFY)))
        else $error("map written outside clear or write-back");
`endif

endmodule

// ===== tb/tb.sv =====
// self-checking bench for refcounted_block_allocator: directed and random commands
// keeps its own allocation map and count ledger to predict every reply
// depends on rba_pkg and the allocator rtl only
module tb;
    import rba_pkg::*;

    // command codes past query that the block must reject
    localparam logic [2:0] CMD_SPARE_LO = 3'(CMD_QUERY) + 3'd1;
    localparam logic [2:0] CMD_SPARE_HI = 3'h7;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         SETTLE_GAP   = 8;

    // ledger of blocks, counts and the replies still owed by the block
    class block_ledger;
        bit                          map_bits [RBA_MAX_BLOCKS];
        logic [RBA_COUNT_WIDTH-1:0]  counts   [RBA_MAX_BLOCKS];
        int unsigned                 used;
        logic [31:0]                 base;
        logic [RBA_TOTAL_WIDTH-1:0]  total;
        rsp_item_t                   owed_replies [$];
        int unsigned                 errors;
        int unsigned                 replies_seen;

        function new();
            foreach (map_bits[i])
            begin
                map_bits[i] = 1'b0;
                counts[i]   = RBA_COUNT_ONE;
            end
            used         = 0;
            base         = '0;
            total        = RBA_TOTAL_RESET;
            errors       = 0;
            replies_seen = 0;
        endfunction

        function void set_layout(logic [31:0] new_base, logic [RBA_TOTAL_WIDTH-1:0] new_total);
            base  = new_base;
            total = new_total;
        endfunction

        function int unsigned usable();
            return (total > RBA_MAX_BLOCKS) ? RBA_MAX_BLOCKS : int'(total);
        endfunction

        function int unsigned free_left();
            return (usable() > used) ? usable() - used : 0;
        endfunction

        function int pending();
            return owed_replies.size();
        endfunction

        // absolute block number to map index, no wrap allowed
        function bit locate(logic [31:0] blk, output int unsigned idx);
            longint unsigned b;
            longint unsigned s;
            b   = blk;
            s   = base;
            idx = 0;
            if (b < s)
                return 1'b0;
            if (b - s >= usable())
                return 1'b0;
            idx = int'(b - s);
            return 1'b1;
        endfunction

        function void release_block(int unsigned idx);
            if (map_bits[idx])
            begin
                map_bits[idx] = 1'b0;
                if (used > 0)
                    used--;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("tb: mismatch on reply %0d: %s", replies_seen, msg);
        endtask

        // apply one accepted command and queue the reply it must produce
        function void note_command(cmd_item_t c);
            rsp_item_t   e;
            int unsigned idx;
            int unsigned k;
            bit          hit;
            e        = '0;
            e.status = STS_OK;
            idx      = 0;
            hit      = 1'b0;
            case (c.command)
                CMD_ALLOC:
                begin
                    if (free_left() != 0)
                    begin
                        for (k = 0; k < usable() && !hit; k++)
                        begin
                            if (!map_bits[k])
                            begin
                                hit = 1'b1;
                                idx = k;
                            end
                        end
                    end
                    if (hit)
                    begin
                        map_bits[idx]     = 1'b1;
                        counts[idx]       = RBA_COUNT_ONE;
                        used++;
                        e.granted_block   = base + 32'(idx);
                        e.reference_count = RBA_COUNT_ONE;
                        e.is_allocated    = 1'b1;
                    end
                    else
                    begin
                        e.status = STS_NO_SPACE;
                    end
                end
                CMD_FREE, CMD_INC, CMD_DEC, CMD_QUERY:
                begin
                    if (!locate(c.block_number, idx))
                    begin
                        e.status = STS_INVALID;
                    end
                    else
                    begin
                        case (c.command)
                            CMD_FREE:
                            begin
                                if (!map_bits[idx])
                                    e.status = STS_INVALID;
                                else if (counts[idx] > RBA_COUNT_ONE)
                                    counts[idx]--;
                                else
                                begin
                                    counts[idx] = '0;
                                    release_block(idx);
                                end
                            end
                            CMD_INC:
                            begin
                                if (counts[idx] >= RBA_COUNT_LIMIT)
                                    e.status = STS_RANGE;
                                else
                                    counts[idx]++;
                            end
                            CMD_DEC:
                            begin
                                if (counts[idx] == '0)
                                    e.status = STS_RANGE;
                                else
                                begin
                                    counts[idx]--;
                                    if (counts[idx] == '0)
                                        release_block(idx);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        e.reference_count = counts[idx];
                        e.is_allocated    = map_bits[idx];
                    end
                end
                default:
                begin
                    e.status = STS_INVALID;
                end
            endcase
            e.blocks_free = RBA_TOTAL_WIDTH'(free_left());
            owed_replies = {owed_replies, e};
        endfunction

        // compare one reply with the oldest owed one
        task check_reply(rsp_item_t got);
            rsp_item_t want;
            replies_seen++;
            if (owed_replies.size() == 0)
            begin
                report("reply with no transaction outstanding");
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.granted_block !== want.granted_block)
                report($sformatf("granted_block %h, want %h",
                                 got.granted_block, want.granted_block));
            if (got.reference_count !== want.reference_count)
                report($sformatf("reference_count %0d, want %0d",
                                 got.reference_count, want.reference_count));
            if (got.is_allocated !== want.is_allocated)
                report($sformatf("is_allocated %b, want %b",
                                 got.is_allocated, want.is_allocated));
            if (got.blocks_free !== want.blocks_free)
                report($sformatf("blocks_free %0d, want %0d",
                                 got.blocks_free, want.blocks_free));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cmd_valid;
    logic                      cmd_ready;
    cmd_item_t                 cmd;
    logic                      rsp_valid;
    logic                      rsp_ready;
    rsp_item_t                 rsp;
    logic                      cfg_we;
    cfg_reg_t                  cfg_index;
    logic [RBA_CFG_WIDTH-1:0]  cfg_data;

    block_ledger               ledger = new();
    bit                        idle_on;
    bit                        long_hold;
    logic [31:0]               cur_base;
    int unsigned               cur_span;

    refcounted_block_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // watch both channels for completed transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                ledger.note_command(cmd);
            if (rsp_valid && rsp_ready)
                ledger.check_reply(rsp);
        end
    end

    // reply side: one long hold-off on request, short random stalls while idle_on is set
    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        rsp_ready  = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // offer one command and hold it until accepted
    task automatic issue(logic [2:0] op, logic [31:0] blk);
        cmd_item_t c;
        c.command      = op;
        c.block_number = blk;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // wait until every owed reply is back and the block has gone quiet
    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // write both layout registers on back-to-back edges
    task automatic set_layout(logic [31:0] new_base, logic [RBA_TOTAL_WIDTH-1:0] new_total);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DATA_BASE;
        cfg_data  <= new_base;
        @(posedge clk);
        cfg_index <= REG_DATA_TOTAL;
        cfg_data  <= RBA_CFG_WIDTH'(new_total);
        @(posedge clk);
        cfg_we    <= 1'b0;
        ledger.set_layout(new_base, new_total);
        cur_base = new_base;
        cur_span = ledger.usable();
    endtask

    // mostly addresses inside the window, some at its edges and some anywhere
    function automatic logic [31:0] pick_block();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return (cur_span == 0) ? cur_base : cur_base + $urandom_range(0, cur_span - 1);
        else if (roll < 80)
            return cur_base + cur_span;
        else if (roll < 85)
            return cur_base - 1;
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return CMD_ALLOC;
        else if (roll < 50)
            return CMD_FREE;
        else if (roll < 65)
            return CMD_INC;
        else if (roll < 80)
            return CMD_DEC;
        else if (roll < 95)
            return CMD_QUERY;
        return 3'($urandom_range(int'(CMD_SPARE_LO), int'(CMD_SPARE_HI)));
    endfunction

    task automatic random_phase(logic [31:0] new_base, logic [RBA_TOTAL_WIDTH-1:0] new_total,
                                int items, bit hold);
        set_layout(new_base, new_total);
        if (hold)
            long_hold = 1'b1;
        repeat (items) issue(pick_op(), pick_block());
    endtask

    // drive one block's count up to the limit with more increments than fit, then issue a free and a dec
    task automatic saturate_one();
        logic [31:0] blk;
        blk = cur_base + $urandom_range(0, cur_span - 1);
        repeat (260) issue(CMD_INC, blk);
        issue(CMD_FREE, blk);
        issue(CMD_DEC, blk);
    endtask

    initial
    begin
        logic [31:0] b;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_DATA_BASE;
        cfg_data  = '0;
        idle_on   = 1'b1;
        long_hold = 1'b0;
        cur_base  = '0;
        cur_span  = RBA_MAX_BLOCKS;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: four-block window, every command and corner
        b = 32'h0000_0100;
        set_layout(b, 13'd4);
        issue(CMD_QUERY, b);
        issue(CMD_FREE, b);
        issue(CMD_INC, b);
        issue(CMD_DEC, b);
        issue(CMD_ALLOC, 32'h0);
        issue(CMD_ALLOC, 32'hFFFF_FFFF);
        issue(CMD_ALLOC, 32'hAAAA_5555);
        issue(CMD_ALLOC, 32'h5555_AAAA);
        issue(CMD_ALLOC, 32'h0);
        issue(CMD_INC, b);
        issue(CMD_FREE, b);
        issue(CMD_FREE, b);
        issue(CMD_DEC, b);
        issue(CMD_QUERY, b - 1);
        issue(CMD_QUERY, b + 4);
        issue(CMD_QUERY, 32'hFFFF_FFFF);
        issue(CMD_QUERY, 32'h0);
        issue(CMD_SPARE_LO, b);
        issue(CMD_SPARE_LO + 3'd1, b);
        issue(CMD_SPARE_HI, b);
        issue(CMD_ALLOC, b);
        issue(CMD_DEC, b);
        issue(CMD_DEC, b + 1);
        issue(CMD_QUERY, b + 3);

        // random: small windows fill up, edge bases, clamped and empty totals
        random_phase(32'h0, 13'd8, 250, 1'b1);
        random_phase(32'hFFFF_FFF0, 13'd32, 200, 1'b0);
        random_phase(32'hFFFF_FFFF, 13'd1, 150, 1'b0);
        random_phase($urandom, 13'h1FFF, 150, 1'b0);
        random_phase(32'h40, 13'd0, 60, 1'b0);
        random_phase(32'h40, 13'd32, 40, 1'b0);
        saturate_one();
        random_phase(32'h0, RBA_TOTAL_RESET, 100, 1'b0);
        idle_on = 1'b0;
        random_phase(32'h800, 13'd24, 250, 1'b0);

        settle();
        repeat (20) @(posedge clk);
        if (ledger.pending() != 0)
            ledger.report("replies still owed at end of run");
        if (ledger.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // overall time limit
    initial
    begin
        #4000000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rba_pkg.sv
src/rba_ram.sv
src/rba_summary.sv
src/refcounted_block_allocator.sv
tb/tb.sv
